// ----- rtl/tspat_pkg.sv -----
// ----------------------------------------------------------------------------
// Program association section parser package
// Shared types and constants for the section parser and its search cells.
// ----------------------------------------------------------------------------
package tspat_pkg;

   localparam int MAX_PROGRAMS_DEF     = 16;
   localparam int MAX_TRACKED_PIDS_DEF = 32;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 12;
   localparam int LEN_W  = 12;
   localparam int PROG_W = 16;
   localparam int PID_W  = 13;
   localparam int ENTRY_W = 24;

   localparam logic [BYTE_W-1:0] TABLE_ID_PAT = 8'h00;
   localparam logic [POS_W-1:0]  POS_MAX      = 12'hFFF;
   localparam logic [POS_W-1:0]  POS_LEN_HI   = 12'd1;
   localparam logic [POS_W-1:0]  POS_LEN_LO   = 12'd2;
   localparam logic [POS_W-1:0]  ENTRY_START  = 12'd8;
   localparam logic [LEN_W-1:0]  LEN_OVERHEAD = 12'd9;
   localparam logic [1:0]        ENTRY_LAST   = 2'b11;

   typedef enum logic [1:0] {
      KIND_UPDATED   = 2'd0,
      KIND_ADDED     = 2'd1,
      KIND_FULL      = 2'd2,
      KIND_BAD_TABLE = 2'd3
   } tspat_kind_type;

   // Search token that walks the cell chains.
   typedef struct packed {
      logic                 valid;
      logic                 hit;
      logic                 added;
      tspat_kind_type       kind;
      logic [PROG_W-1:0]    prog;
      logic [PID_W-1:0]     pid;
   } tspat_tok_type;

   typedef struct packed {
      tspat_kind_type       kind;
      logic [PROG_W-1:0]    prog;
      logic [PID_W-1:0]     pid;
      logic                 newly;
      logic                 full;
   } tspat_rsp_type;

endpackage

// ----- rtl/tspat_ifs.sv -----
// ----------------------------------------------------------------------------
// Section parser channel interfaces
// Valid/ready channels for section bytes and parse results.
// ----------------------------------------------------------------------------
interface tspat_req_if;
   import tspat_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_byte;
   logic                section_start;
   modport source (output valid, data_byte, section_start, input ready);
   modport sink   (input valid, data_byte, section_start, output ready);
endinterface

interface tspat_rsp_if;
   import tspat_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          event_kind;
   logic [PROG_W-1:0]   prog_id;
   logic [PID_W-1:0]    map_pid;
   logic                pid_newly_tracked;
   logic                pid_set_full;
   modport source (output valid, event_kind, prog_id, map_pid,
                   pid_newly_tracked, pid_set_full, input ready);
   modport sink   (input valid, event_kind, prog_id, map_pid,
                   pid_newly_tracked, pid_set_full, output ready);
endinterface

// ----- rtl/tspat_prog_cell.sv -----
// ----------------------------------------------------------------------------
// Program table cell
// Holds one program entry; matches, updates or appends as the token passes.
// ----------------------------------------------------------------------------
module tspat_prog_cell #(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [COUNT_W-1:0]      count,
   input  tspat_pkg::tspat_tok_type tok_in,
   output tspat_pkg::tspat_tok_type tok_out
);
   import tspat_pkg::*;

   localparam logic [COUNT_W-1:0] IDX_C = COUNT_W'(INDEX);

   logic [PROG_W-1:0] num_ff;
   logic [PID_W-1:0]  pid_ff;
   tspat_tok_type     tok_ff;
   tspat_tok_type     tok_in_next;
   logic              occupied;
   logic              hit_here;
   logic              append_here;

   assign occupied    = IDX_C < count;
   assign hit_here    = tok_in.valid && occupied && !tok_in.hit && (num_ff == tok_in.prog);
   assign append_here = tok_in.valid && (IDX_C == count) && !tok_in.hit;

   always_comb begin
      tok_in_next = tok_in;
      if (hit_here) begin
         tok_in_next.hit = 1'b1;
      end
      if (append_here) begin
         tok_in_next.added = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.hit   <= tok_in_next.hit;
      tok_ff.added <= tok_in_next.added;
      tok_ff.kind  <= tok_in_next.kind;
      tok_ff.prog  <= tok_in_next.prog;
      tok_ff.pid   <= tok_in_next.pid;
      if (hit_here) begin
         pid_ff <= tok_in.pid;
      end
      if (append_here) begin
         num_ff <= tok_in.prog;
         pid_ff <= tok_in.pid;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- rtl/tspat_pid_cell.sv -----
// ----------------------------------------------------------------------------
// Tracked PID cell
// Holds one tracked PID; flags a match or appends the PID as the token passes.
// ----------------------------------------------------------------------------
module tspat_pid_cell #(
   parameter int INDEX   = 0,
   parameter int COUNT_W = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [COUNT_W-1:0]      count,
   input  tspat_pkg::tspat_tok_type tok_in,
   output tspat_pkg::tspat_tok_type tok_out
);
   import tspat_pkg::*;

   localparam logic [COUNT_W-1:0] IDX_C = COUNT_W'(INDEX);

   logic [PID_W-1:0] pid_ff;
   tspat_tok_type    tok_ff;
   tspat_tok_type    tok_in_next;
   logic             occupied;
   logic             hit_here;
   logic             append_here;

   assign occupied    = IDX_C < count;
   assign hit_here    = tok_in.valid && occupied && !tok_in.hit && (pid_ff == tok_in.pid);
   assign append_here = tok_in.valid && (IDX_C == count) && !tok_in.hit;

   always_comb begin
      tok_in_next = tok_in;
      if (hit_here) begin
         tok_in_next.hit = 1'b1;
      end
      if (append_here) begin
         tok_in_next.added = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.hit   <= tok_in_next.hit;
      tok_ff.added <= tok_in_next.added;
      tok_ff.kind  <= tok_in_next.kind;
      tok_ff.prog  <= tok_in_next.prog;
      tok_ff.pid   <= tok_in_next.pid;
      if (append_here) begin
         pid_ff <= tok_in.pid;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ----- rtl/ts_pat_section_parser.sv -----
// ----------------------------------------------------------------------------
// Program association section parser
// Parses section bytes and keeps a program table and a tracked PID set.
// ----------------------------------------------------------------------------
//   Channel    Direction  Transfer
//   req_chan   in         one section byte with a section start flag
//   rsp_chan   out        one program event or a bad table id event
//
// A byte that launches no table search and gives no result leaves the byte
// channel ready. A bad table id result passes through the pending register and
// then the output register. The last byte of an entry with a nonzero program
// number walks a token through the program chain and then the PID chain, one
// cell per cycle; when the program table is full, the token stops at the end
// of the program chain. Reset is synchronous and needs no clearing pass. Bytes
// stall while a search runs or a result is pending; the result moves on once
// the output register is empty or its transfer happens.
module ts_pat_section_parser #(
   parameter int MAX_PROGRAMS     = tspat_pkg::MAX_PROGRAMS_DEF,
   parameter int MAX_TRACKED_PIDS = tspat_pkg::MAX_TRACKED_PIDS_DEF
) (
   input logic        clock,
   input logic        reset,
   tspat_req_if.sink  req_chan,
   tspat_rsp_if.source rsp_chan
);
   import tspat_pkg::*;

   localparam int PC_W = $clog2(MAX_PROGRAMS + 1);
   localparam int TC_W = $clog2(MAX_TRACKED_PIDS + 1);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic               ignore_ff, ignore_in;
   logic [PC_W-1:0]    prog_count_ff, prog_count_in;
   logic [TC_W-1:0]    tracked_count_ff, tracked_count_in;
   logic               busy_ff, busy_in;
   tspat_tok_type      launch_ff, launch_in;
   logic               pend_valid_ff, pend_valid_in;
   tspat_rsp_type      pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tspat_rsp_type      rsp_ff, rsp_in;

   tspat_tok_type      prog_tok [MAX_PROGRAMS];
   tspat_tok_type      pid_tok [MAX_TRACKED_PIDS];
   tspat_tok_type      prog_tail;
   tspat_tok_type      pid_head;
   tspat_tok_type      pid_tail;
   tspat_kind_type     prog_kind;
   logic               prog_full;

   logic               req_accept;
   logic               bad_table;
   logic [POS_W-1:0]   rel;
   logic [LEN_W-1:0]   len_minus;
   logic [LEN_W-3:0]   entry_total;
   logic               in_entry;
   logic               pend_load;
   logic               rsp_load;

   assign req_chan.ready = !busy_ff && !pend_valid_ff;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign rel         = pos_ff - ENTRY_START;
   assign len_minus   = len_ff - LEN_OVERHEAD;
   assign entry_total = (len_ff >= LEN_OVERHEAD) ? len_minus[LEN_W-1:2] : '0;
   assign in_entry    = (pos_ff >= ENTRY_START) && (rel[POS_W-1:2] < entry_total);

   always_comb begin
      pos_in          = pos_ff;
      len_in          = len_ff;
      entry_in        = entry_ff;
      ignore_in       = ignore_ff;
      bad_table       = 1'b0;
      launch_in       = '0;
      launch_in.kind  = KIND_ADDED;
      launch_in.prog  = entry_ff[ENTRY_W-1:8];
      launch_in.pid   = {entry_ff[PID_W-9:0], req_chan.data_byte};
      if (req_accept) begin
         if (req_chan.section_start) begin
            pos_in   = POS_LEN_HI;
            len_in   = '0;
            entry_in = '0;
            if (req_chan.data_byte != TABLE_ID_PAT) begin
               ignore_in = 1'b1;
               bad_table = 1'b1;
            end else begin
               ignore_in = 1'b0;
            end
         end else if (!ignore_ff) begin
            if (pos_ff < POS_MAX) begin
               pos_in = pos_ff + POS_W'(1);
            end
            if (pos_ff == POS_LEN_HI) begin
               len_in = {req_chan.data_byte[3:0], 8'h00};
            end else if (pos_ff == POS_LEN_LO) begin
               len_in = len_ff | {4'h0, req_chan.data_byte};
            end else if (in_entry) begin
               if (rel[1:0] != ENTRY_LAST) begin
                  entry_in = {entry_ff[15:0], req_chan.data_byte};
               end else if (launch_in.prog != '0) begin
                  launch_in.valid = 1'b1;
               end
            end
         end
      end
   end

   generate
      for (genvar i = 0; i < MAX_PROGRAMS; i++) begin : g_prog
         if (i == 0) begin : g_first
            tspat_prog_cell #(.INDEX(i), .COUNT_W(PC_W)) u_cell (
               .clock   (clock),
               .reset   (reset),
               .count   (prog_count_ff),
               .tok_in  (launch_ff),
               .tok_out (prog_tok[i])
            );
         end else begin : g_next
            tspat_prog_cell #(.INDEX(i), .COUNT_W(PC_W)) u_cell (
               .clock   (clock),
               .reset   (reset),
               .count   (prog_count_ff),
               .tok_in  (prog_tok[i-1]),
               .tok_out (prog_tok[i])
            );
         end
      end
      for (genvar j = 0; j < MAX_TRACKED_PIDS; j++) begin : g_pid
         if (j == 0) begin : g_first
            tspat_pid_cell #(.INDEX(j), .COUNT_W(TC_W)) u_cell (
               .clock   (clock),
               .reset   (reset),
               .count   (tracked_count_ff),
               .tok_in  (pid_head),
               .tok_out (pid_tok[j])
            );
         end else begin : g_next
            tspat_pid_cell #(.INDEX(j), .COUNT_W(TC_W)) u_cell (
               .clock   (clock),
               .reset   (reset),
               .count   (tracked_count_ff),
               .tok_in  (pid_tok[j-1]),
               .tok_out (pid_tok[j])
            );
         end
      end
   endgenerate

   assign prog_tail = prog_tok[MAX_PROGRAMS-1];
   assign pid_tail  = pid_tok[MAX_TRACKED_PIDS-1];

   always_comb begin
      priority if (prog_tail.hit) begin
         prog_kind = KIND_UPDATED;
      end else if (prog_tail.added) begin
         prog_kind = KIND_ADDED;
      end else begin
         prog_kind = KIND_FULL;
      end
      prog_full      = prog_tail.valid && !prog_tail.hit && !prog_tail.added;
      pid_head       = prog_tail;
      pid_head.valid = prog_tail.valid && !prog_full;
      pid_head.hit   = 1'b0;
      pid_head.added = 1'b0;
      pid_head.kind  = prog_kind;
   end

   always_comb begin
      pend_load        = 1'b0;
      pend_in          = pend_ff;
      busy_in          = busy_ff;
      prog_count_in    = prog_count_ff;
      tracked_count_in = tracked_count_ff;
      if (launch_in.valid) begin
         busy_in = 1'b1;
      end
      if (prog_tail.valid && prog_tail.added) begin
         prog_count_in = prog_count_ff + PC_W'(1);
      end
      if (pid_tail.valid && pid_tail.added) begin
         tracked_count_in = tracked_count_ff + TC_W'(1);
      end
      if (bad_table) begin
         pend_load     = 1'b1;
         pend_in.kind  = KIND_BAD_TABLE;
         pend_in.prog  = '0;
         pend_in.pid   = '0;
         pend_in.newly = 1'b0;
         pend_in.full  = 1'b0;
      end else if (prog_full) begin
         pend_load     = 1'b1;
         busy_in       = 1'b0;
         pend_in.kind  = KIND_FULL;
         pend_in.prog  = prog_tail.prog;
         pend_in.pid   = prog_tail.pid;
         pend_in.newly = 1'b0;
         pend_in.full  = 1'b0;
      end else if (pid_tail.valid) begin
         pend_load     = 1'b1;
         busy_in       = 1'b0;
         pend_in.kind  = pid_tail.kind;
         pend_in.prog  = pid_tail.prog;
         pend_in.pid   = pid_tail.pid;
         pend_in.newly = pid_tail.added;
         pend_in.full  = !pid_tail.hit && !pid_tail.added;
      end
   end

   assign rsp_load = pend_valid_ff && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_in        = rsp_load ? pend_ff : rsp_ff;
      rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
      pend_valid_in = pend_load || (pend_valid_ff && !rsp_load);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff           <= '0;
         len_ff           <= '0;
         entry_ff         <= '0;
         ignore_ff        <= 1'b1;
         prog_count_ff    <= '0;
         tracked_count_ff <= '0;
         busy_ff          <= 1'b0;
         launch_ff.valid  <= 1'b0;
         pend_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pos_ff           <= pos_in;
         len_ff           <= len_in;
         entry_ff         <= entry_in;
         ignore_ff        <= ignore_in;
         prog_count_ff    <= prog_count_in;
         tracked_count_ff <= tracked_count_in;
         busy_ff          <= busy_in;
         launch_ff.valid  <= launch_in.valid;
         pend_valid_ff    <= pend_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      launch_ff.hit   <= launch_in.hit;
      launch_ff.added <= launch_in.added;
      launch_ff.kind  <= launch_in.kind;
      launch_ff.prog  <= launch_in.prog;
      launch_ff.pid   <= launch_in.pid;
      pend_ff         <= pend_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.event_kind        = rsp_ff.kind;
   assign rsp_chan.prog_id           = rsp_ff.prog;
   assign rsp_chan.map_pid           = rsp_ff.pid;
   assign rsp_chan.pid_newly_tracked = rsp_ff.newly;
   assign rsp_chan.pid_set_full      = rsp_ff.full;

   // A new result never lands on a result that is still pending.
   a_pend_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      pend_load |-> !pend_valid_ff)
      else $error("pending result overwritten");

   // Tokens leave the program chain only during a search.
   a_tail_while_busy: assert property (@(posedge clock) disable iff (reset)
      prog_tail.valid |-> busy_ff)
      else $error("token outside of a search");

   // Only one token is in flight at a time.
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      pid_tail.valid |-> !prog_tail.valid && !launch_ff.valid)
      else $error("more than one token in flight");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (prog_count_ff <= PC_W'(MAX_PROGRAMS)) &&
      (tracked_count_ff <= TC_W'(MAX_TRACKED_PIDS)))
      else $error("table count beyond capacity");

endmodule

// ----- sim/ts_pat_section_parser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Program association section parser testbench
// Streams section bytes into the parser under random flow control and checks
// every result transfer against a cycle-free model of the program table and
// the tracked PID set kept alongside the run.
// ----------------------------------------------------------------------------
module ts_pat_section_parser_tb;
   import tspat_pkg::*;

   localparam int RAND_ITEMS  = 850;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = MAX_PROGRAMS_DEF + MAX_TRACKED_PIDS_DEF + 10;

   class pat_event_board;
      logic [POS_W-1:0]   byte_pos;
      logic [LEN_W-1:0]   sec_len;
      logic [ENTRY_W-1:0] entry_acc;
      bit                 skip_section;
      logic [PROG_W-1:0]  prog_tab[MAX_PROGRAMS_DEF];
      logic [PID_W-1:0]   prog_pid[MAX_PROGRAMS_DEF];
      int                 prog_count;
      logic [PID_W-1:0]   pid_tab[MAX_TRACKED_PIDS_DEF];
      int                 pid_count;
      tspat_rsp_type      pending_events[$];
      int                 errors;

      function new();
         byte_pos     = '0;
         sec_len      = '0;
         entry_acc    = '0;
         skip_section = 1'b1;
         prog_count   = 0;
         pid_count    = 0;
         errors       = 0;
      endfunction

      function int pending();
         return pending_events.size();
      endfunction

      function void take_byte(logic [BYTE_W-1:0] b, logic start);
         logic [POS_W-1:0]  pos;
         logic [POS_W-1:0]  rel;
         logic [LEN_W-1:0]  n_entries;
         logic [PROG_W-1:0] prog;
         logic [PID_W-1:0]  pid;
         tspat_rsp_type     ev;
         bit                hit;
         int                i;
         ev = '0;
         if (start) begin
            byte_pos     = POS_LEN_HI;
            sec_len      = '0;
            entry_acc    = '0;
            skip_section = (b != TABLE_ID_PAT);
            if (skip_section) begin
               ev.kind = KIND_BAD_TABLE;
               pending_events.push_back(ev);
            end
            return;
         end
         if (skip_section) return;
         pos = byte_pos;
         if (byte_pos < POS_MAX) byte_pos = byte_pos + POS_W'(1);
         if (pos == POS_LEN_HI) begin
            sec_len = {b[3:0], 8'h00};
            return;
         end
         if (pos == POS_LEN_LO) begin
            sec_len[7:0] = b;
            return;
         end
         if (pos < ENTRY_START) return;
         n_entries = (sec_len >= LEN_OVERHEAD) ? (sec_len - LEN_OVERHEAD) >> 2 : '0;
         rel = pos - ENTRY_START;
         if ((rel >> 2) >= n_entries) return;
         if (rel[1:0] != ENTRY_LAST) begin
            entry_acc = {entry_acc[15:0], b};
            return;
         end

         prog = entry_acc[23:8];
         pid  = {entry_acc[4:0], b};
         if (prog == '0) return;
         ev.prog = prog;
         ev.pid  = pid;
         hit = 1'b0;
         for (i = 0; i < prog_count; i++) begin
            if (prog_tab[i] == prog) begin
               prog_pid[i] = pid;
               hit = 1'b1;
               break;
            end
         end
         if (hit) begin
            ev.kind = KIND_UPDATED;
         end else if (prog_count < MAX_PROGRAMS_DEF) begin
            prog_tab[prog_count] = prog;
            prog_pid[prog_count] = pid;
            prog_count++;
            ev.kind = KIND_ADDED;
         end else begin
            ev.kind = KIND_FULL;
            pending_events.push_back(ev);
            return;
         end
         hit = 1'b0;
         for (i = 0; i < pid_count; i++) begin
            if (pid_tab[i] == pid) begin
               hit = 1'b1;
               break;
            end
         end
         if (!hit) begin
            if (pid_count < MAX_TRACKED_PIDS_DEF) begin
               pid_tab[pid_count] = pid;
               pid_count++;
               ev.newly = 1'b1;
            end else begin
               ev.full = 1'b1;
            end
         end
         pending_events.push_back(ev);
      endfunction

      function void check_event(logic [1:0] kind, logic [PROG_W-1:0] prog,
                                logic [PID_W-1:0] pid, logic newly, logic full);
         tspat_rsp_type ev;
         if (pending_events.size() == 0) begin
            $error("result transfer with no event expected: kind %0d program %0d pid %0d",
                   kind, prog, pid);
            errors++;
            return;
         end
         ev = pending_events.pop_front();
         if (ev.kind !== kind) begin
            $error("event_kind: expected %0d, actual %0d", ev.kind, kind);
            errors++;
         end
         if (ev.prog !== prog) begin
            $error("prog_id: expected %0d, actual %0d", ev.prog, prog);
            errors++;
         end
         if (ev.pid !== pid) begin
            $error("map_pid: expected %0d, actual %0d", ev.pid, pid);
            errors++;
         end
         if (ev.newly !== newly) begin
            $error("pid_newly_tracked: expected %0d, actual %0d", ev.newly, newly);
            errors++;
         end
         if (ev.full !== full) begin
            $error("pid_set_full: expected %0d, actual %0d", ev.full, full);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tspat_req_if req_if ();
   tspat_rsp_if rsp_if ();

   ts_pat_section_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   pat_event_board    board = new();
   logic [BYTE_W-1:0] section_bytes[$];
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                bytes_sent    = 0;
   int                stall_cycles  = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         board.check_event(rsp_if.event_kind, rsp_if.prog_id, rsp_if.map_pid,
                           rsp_if.pid_newly_tracked, rsp_if.pid_set_full);
      end
      rsp_if.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.data_byte     <= b;
      req_if.section_start <= start;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.take_byte(b, start);
      bytes_sent++;
   endtask

   task automatic send_section();
      int i;
      for (i = 0; i < section_bytes.size(); i++) send_byte(section_bytes[i], i == 0);
   endtask

   task automatic build_section();
      int                pick;
      int                len;
      int                n_entries;
      int                keep;
      logic [PROG_W-1:0] prog;
      logic [PID_W-1:0]  pid;
      section_bytes.delete();
      pick = $urandom_range(99);
      if (pick < 6) begin
         section_bytes.push_back(8'($urandom_range(1, 255)));
         repeat ($urandom_range(0, 3)) section_bytes.push_back(8'($urandom));
         return;
      end
      if (pick < 10) begin
         repeat ($urandom_range(1, 6)) section_bytes.push_back(8'($urandom));
         return;
      end
      if (pick < 16) len = $urandom_range(0, LEN_OVERHEAD - 1);
      else if (pick < 20) len = $urandom_range(29, 4095);
      else len = LEN_OVERHEAD + 4 * $urandom_range(0, 4) + $urandom_range(0, 3);
      section_bytes.push_back(TABLE_ID_PAT);
      section_bytes.push_back({4'($urandom), 4'(len >> 8)});
      section_bytes.push_back(8'(len));
      repeat (5) section_bytes.push_back(8'($urandom));
      n_entries = (len >= LEN_OVERHEAD) ? (len - LEN_OVERHEAD) / 4 : 0;
      if (n_entries > 6) n_entries = $urandom_range(1, 6);
      repeat (n_entries) begin
         pick = $urandom_range(99);
         if (pick < 10) prog = '0;
         else if (pick < 85) prog = 16'($urandom_range(1, 20));
         else prog = 16'($urandom_range(1, 65535));
         pid = ($urandom_range(99) < 80) ? 13'($urandom_range(0, 39)) : 13'($urandom);
         section_bytes.push_back(prog[15:8]);
         section_bytes.push_back(prog[7:0]);
         section_bytes.push_back({3'($urandom), pid[12:8]});
         section_bytes.push_back(pid[7:0]);
      end
      if (len <= 28) begin
         repeat ($urandom_range(0, 6)) section_bytes.push_back(8'($urandom));
      end
      if ($urandom_range(99) < 10) begin
         keep = $urandom_range(1, section_bytes.size());
         while (section_bytes.size() > keep) void'(section_bytes.pop_back());
      end
   endtask

   initial begin
      int phase;
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.data_byte     <= '0;
      req_if.section_start <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 11;
      recv_idle_pct = 45;
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      section_bytes = '{8'h00, 8'hF0, 8'h0D, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF,
                        8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_section();
      section_bytes = '{8'h00, 8'h00, 8'h05, 8'h33};
      send_section();
      section_bytes = '{8'h00, 8'h00, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                        8'h00, 8'h00, 8'hE0, 8'h01};
      send_section();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 11;
               recv_idle_pct = 45;
            end
            1: begin
               send_idle_pct = 45;
               recv_idle_pct = 11;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (bytes_sent < (phase + 1) * RAND_ITEMS / 3) begin
            build_section();
            send_section();
         end
      end
      req_if.valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
